FILE: rtl/core/integer_field_formatter_top_assert.svh
// assertion macros for the integer field formatter top level
// expects clk_i and rst_ni in the scope of use
`ifndef INTEGER_FIELD_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IFF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define IFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/iff_pkg.sv
// shared types, constants and helper functions of the integer field formatter
// no dependencies
`timescale 1ns / 1ps

package iff_pkg;

  // longest conversion in characters
  localparam int MAX_FIELD = 63;
  localparam int PREC_MAX  = MAX_FIELD - 1;

  // fixed field widths of the request and character beats
  localparam int VAL_W   = 32;
  localparam int FIELD_W = 6;
  localparam int CHAR_W  = 8;

  // character counters hold the field fields and MAX_FIELD itself
  localparam int CNT_RAW = $clog2(MAX_FIELD + 1);
  localparam int CNT_W   = (CNT_RAW > FIELD_W) ? CNT_RAW : FIELD_W;

  // digit store: ten decimal digits cover 32 bits, hex uses eight of them
  localparam int NDEC      = 10;
  localparam int DIG_W     = 4;
  localparam int BCD_W     = NDEC * DIG_W;
  localparam int DIG_IDX_W = $clog2(NDEC);

  // shift-add-3 conversion: bits handled per pipeline stage
  localparam int BITS_PER_STAGE = 4;
  localparam int NUM_STAGES     = VAL_W / BITS_PER_STAGE;

  localparam logic [DIG_W-1:0]  DEC_BASE    = 4'd10;
  localparam logic [DIG_W-1:0]  DABBLE_MIN  = 4'd5;
  localparam logic [DIG_W-1:0]  DABBLE_ADD  = 4'd3;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_HEX_A = 8'h61;

  typedef struct packed {
    logic             is_hex;
    logic             neg;
    logic [CNT_W-1:0] width;
    logic [CNT_W-1:0] prec;
  } iff_side_t;

  typedef struct packed {
    iff_side_t        side;
    logic [BCD_W-1:0] bcd;
    logic [VAL_W-1:0] bin;
  } iff_conv_t;

  typedef struct packed {
    logic [NDEC-1:0][DIG_W-1:0] digits;
    logic [CNT_W-1:0]           space_end;
    logic [CNT_W-1:0]           sign_end;
    logic [CNT_W-1:0]           zero_end;
    logic [CNT_W-1:0]           total;
  } iff_fmt_t;

  typedef struct packed {
    logic busy;
    logic load_last;
  } iff_emit_stat_t;

  // one shift-add-3 step; hex skips the adjust so the raw nibbles land in bcd
  function automatic iff_conv_t dabble_step(iff_conv_t c);
    iff_conv_t        r;
    logic [BCD_W-1:0] adj;
    adj = c.bcd;
    if (!c.side.is_hex) begin
      for (int i = 0; i < NDEC; i++) begin
        if (adj[i*DIG_W +: DIG_W] >= DABBLE_MIN) begin
          adj[i*DIG_W +: DIG_W] = adj[i*DIG_W +: DIG_W] + DABBLE_ADD;
        end
      end
    end
    r     = c;
    r.bcd = {adj[BCD_W-2:0], c.bin[VAL_W-1]};
    r.bin = {c.bin[VAL_W-2:0], 1'b0};
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W - DIG_W){1'b0}}, d};
    if (d < DEC_BASE) begin
      return ASCII_ZERO + dx;
    end
    return ASCII_HEX_A + dx - {{(CHAR_W - DIG_W){1'b0}}, DEC_BASE};
  endfunction

endpackage

FILE: rtl/core/iff_req_if.sv
// request channel of the integer field formatter: valid, ready and one request
// depends on iff_pkg
`timescale 1ns / 1ps

interface iff_req_if import iff_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [VAL_W-1:0]   value_bits;
  logic [FIELD_W-1:0] field_width;
  logic [FIELD_W-1:0] min_digits;

  modport source (
    output valid, req_type, value_bits, field_width, min_digits,
    input  ready
  );
  modport sink (
    input  valid, req_type, value_bits, field_width, min_digits,
    output ready
  );
endinterface

FILE: rtl/core/iff_char_if.sv
// character channel of the integer field formatter: valid, ready and one character
// depends on iff_pkg
`timescale 1ns / 1ps

interface iff_char_if import iff_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (
    output valid, char_code, last_char,
    input  ready
  );
  modport sink (
    input  valid, char_code, last_char,
    output ready
  );
endinterface

FILE: rtl/core/iff_prep.sv
// entry stage: sign and magnitude, saturation of width and precision
// depends on iff_pkg
`timescale 1ns / 1ps

module iff_prep import iff_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               req_type_i,
  input  logic [VAL_W-1:0]   value_bits_i,
  input  logic [FIELD_W-1:0] field_width_i,
  input  logic [FIELD_W-1:0] min_digits_i,
  output logic               valid_o,
  input  logic               ready_i,
  output iff_conv_t          data_o
);

  logic             valid_q;
  iff_conv_t        data_d, data_q;
  logic             neg;
  logic [CNT_W-1:0] width_ext, prec_ext;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    neg       = !req_type_i && value_bits_i[VAL_W-1];
    width_ext = CNT_W'(field_width_i);
    prec_ext  = CNT_W'(min_digits_i);
    data_d             = '0;
    data_d.side.is_hex = req_type_i;
    data_d.side.neg    = neg;
    data_d.side.width  = (width_ext > CNT_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : width_ext;
    data_d.side.prec   = (prec_ext > CNT_W'(PREC_MAX)) ? CNT_W'(PREC_MAX) : prec_ext;
    // most negative value wraps to itself and reads right as unsigned
    data_d.bin         = neg ? (VAL_W'(0) - value_bits_i) : value_bits_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/iff_dabble_stage.sv
// one conversion stage: BITS_PER_STAGE shift-add-3 steps of binary to decimal digits
// depends on iff_pkg
`timescale 1ns / 1ps

module iff_dabble_stage import iff_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  iff_conv_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output iff_conv_t data_o
);

  logic      valid_q;
  iff_conv_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      data_d = dabble_step(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/iff_analyze.sv
// layout stage: digit count, then where spaces, sign, zeros and digits end
// depends on iff_pkg
`timescale 1ns / 1ps

module iff_analyze import iff_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  iff_conv_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output iff_fmt_t  data_o
);

  logic             valid_q;
  iff_fmt_t         data_d, data_q;
  logic [CNT_W-1:0] ndig, zeros, content, spaces, sign_cnt;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    // zero still prints one digit
    ndig = CNT_W'(1);
    for (int i = 0; i < NDEC; i++) begin
      if (data_i.bcd[i*DIG_W +: DIG_W] != '0) begin
        ndig = CNT_W'(i + 1);
      end
    end
    sign_cnt = CNT_W'(data_i.side.neg);
    zeros    = (data_i.side.prec > ndig) ? (data_i.side.prec - ndig) : '0;
    content  = sign_cnt + zeros + ndig;
    spaces   = (data_i.side.width > content) ? (data_i.side.width - content) : '0;

    data_d.digits    = data_i.bcd;
    data_d.space_end = spaces;
    data_d.sign_end  = spaces + sign_cnt;
    data_d.zero_end  = spaces + sign_cnt + zeros;
    data_d.total     = spaces + content;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/core/iff_emitter.sv
// character emitter: walks one laid-out conversion, one character beat a cycle while the output is not stalled
// depends on iff_pkg
`timescale 1ns / 1ps

module iff_emitter import iff_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fmt_valid_i,
  output logic              fmt_ready_o,
  input  iff_fmt_t          fmt_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] char_code_o,
  output logic              last_char_o,
  output iff_emit_stat_t    stat_o
);

  logic                 busy_d, busy_q;
  logic [CNT_W-1:0]     pos_d, pos_q;
  logic                 out_valid_d, out_valid_q;
  logic [CHAR_W-1:0]    char_q;
  logic                 last_q;
  iff_fmt_t             fmt_q;
  logic [CHAR_W-1:0]    ch;
  logic                 is_last;
  logic [CNT_W-1:0]     rem;
  logic [DIG_IDX_W-1:0] didx;
  logic [DIG_W-1:0]     dig;
  logic                 out_free, load, load_last, take;

  always_comb begin
    rem  = fmt_q.total - pos_q - CNT_W'(1);
    didx = rem[DIG_IDX_W-1:0];
    dig  = (didx < DIG_IDX_W'(NDEC)) ? fmt_q.digits[didx] : '0;
    if (pos_q < fmt_q.space_end) begin
      ch = ASCII_SPACE;
    end else if (pos_q < fmt_q.sign_end) begin
      ch = ASCII_MINUS;
    end else if (pos_q < fmt_q.zero_end) begin
      ch = ASCII_ZERO;
    end else begin
      ch = digit_char(dig);
    end
    is_last = (rem == '0);
  end

  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    load        = busy_q && out_free;
    load_last   = load && is_last;
    // next conversion may come in on the cycle its predecessor loads its last beat
    fmt_ready_o = !busy_q || load_last;
    take        = fmt_valid_i && fmt_ready_o;

    busy_d = busy_q;
    if (take) begin
      busy_d = 1'b1;
    end else if (load_last) begin
      busy_d = 1'b0;
    end

    pos_d = pos_q;
    if (take) begin
      pos_d = '0;
    end else if (load) begin
      pos_d = pos_q + CNT_W'(1);
    end

    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      fmt_q <= fmt_i;
    end
    if (load) begin
      char_q <= ch;
      last_q <= is_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign char_code_o      = char_q;
  assign last_char_o      = last_q;
  assign stat_o.busy      = busy_q;
  assign stat_o.load_last = load_last;

endmodule

FILE: rtl/core/integer_field_formatter_top.sv
// Integer field formatter: one request in, its characters out, one beat each.
// A request passes the entry stage, the conversion stages and the layout stage
// before the emitter loads its first character beat into the output register.
// Throughput: one character per cycle while the output is not stalled; a request
// of N characters (1 to 63) holds the emitter until its last beat loads, when the next may enter.
// The 10-stage front end is fully pipelined with valid bits and holds on stall.
// Reset (rst_ni low, asynchronous) clears all valid bits and the emitter.
`timescale 1ns / 1ps

`include "integer_field_formatter_top_assert.svh"

module integer_field_formatter_top import iff_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  iff_req_if.sink      req_i,
  iff_char_if.source   chr_o
);

  logic [NUM_STAGES:0] st_valid, st_ready;
  iff_conv_t           st_data [NUM_STAGES+1];
  logic                fmt_valid, fmt_ready;
  iff_fmt_t            fmt_data;
  iff_emit_stat_t      stat;
  logic                req_beat, fmt_take, emit_free, last_idle;

  iff_prep u_prep (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (req_i.valid),
    .ready_o       (req_i.ready),
    .req_type_i    (req_i.req_type),
    .value_bits_i  (req_i.value_bits),
    .field_width_i (req_i.field_width),
    .min_digits_i  (req_i.min_digits),
    .valid_o       (st_valid[0]),
    .ready_i       (st_ready[0]),
    .data_o        (st_data[0])
  );

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
    iff_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid[g]),
      .ready_o (st_ready[g]),
      .data_i  (st_data[g]),
      .valid_o (st_valid[g+1]),
      .ready_i (st_ready[g+1]),
      .data_o  (st_data[g+1])
    );
  end

  iff_analyze u_analyze (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st_valid[NUM_STAGES]),
    .ready_o (st_ready[NUM_STAGES]),
    .data_i  (st_data[NUM_STAGES]),
    .valid_o (fmt_valid),
    .ready_i (fmt_ready),
    .data_o  (fmt_data)
  );

  iff_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fmt_valid_i (fmt_valid),
    .fmt_ready_o (fmt_ready),
    .fmt_i       (fmt_data),
    .out_valid_o (chr_o.valid),
    .out_ready_i (chr_o.ready),
    .char_code_o (chr_o.char_code),
    .last_char_o (chr_o.last_char),
    .stat_o      (stat)
  );

  assign req_beat  = req_i.valid && req_i.ready;
  assign fmt_take  = fmt_valid && fmt_ready;
  assign emit_free = !stat.busy || stat.load_last;
  assign last_idle = chr_o.valid && chr_o.ready && chr_o.last_char && !stat.busy;

  // a request beat always lands in the entry stage
  `IFF_ASSERT_NEXT(a_req_enters, req_beat, st_valid[0], "request beat lost at entry")

  // emitter takes a conversion only when free or finishing the current one
  `IFF_ASSERT_NOW(a_take_when_free, fmt_take, emit_free, "conversion taken while emitter busy")

  // with nothing left to emit, the output drains after the last character beat
  `IFF_ASSERT_NEXT(a_drain_after_last, last_idle, !chr_o.valid, "character beat without a conversion")

endmodule
